// ----- hw/rtl/cps_pkg.sv -----
package cps_pkg;

  localparam int MaxProcesses = 16;
  localparam int TimeBits = 16;
  localparam int BurstBits = 12;
  localparam int PrioBits = 8;
  localparam int QuantBits = 8;
  localparam int CfgDataBits = 8;

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncTick  = 2'd1,
    FuncClear = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    PolFcfs  = 3'd0,
    PolSjf   = 3'd1,
    PolSrtn  = 3'd2,
    PolPrio  = 3'd3,
    PolPrioP = 3'd4,
    PolRr    = 3'd5
  } policy_e;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgQuantum = 1'b1;

  // Scan kinds issued by the controller.
  typedef enum logic [2:0] {
    ScanBurst = 3'd0,
    ScanRem   = 3'd1,
    ScanPrio  = 3'd2,
    ScanFirst = 3'd3,
    ScanFrom  = 3'd4
  } scan_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic clear;
    logic scan_start;
    scan_e kind;
    logic from_zero;
    logic keep_cur;
    logic commit;
  } cps_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic sel_found;
    logic cur_live;
    logic rr_keep;
    logic start_nonzero;
  } cps_stat_t;

endpackage

// ----- hw/rtl/cps_if.sv -----
interface cps_in_if;
  import cps_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [TimeBits-1:0] arrival_time;
  logic [BurstBits-1:0] burst_time;
  logic [PrioBits-1:0] priority_level;
  modport source(output valid, func, arrival_time, burst_time, priority_level, input ready);
  modport sink(input valid, func, arrival_time, burst_time, priority_level, output ready);
endinterface

interface cps_out_if;
  import cps_pkg::*;
  logic valid;
  logic ready;
  logic [4:0] slot_process;
  logic finished;
  logic [4:0] finished_process;
  logic [TimeBits-1:0] completion_time;
  logic [TimeBits-1:0] turnaround;
  logic [TimeBits-1:0] waiting;
  logic all_done;
  modport source(output valid, slot_process, finished, finished_process, completion_time,
                 turnaround, waiting, all_done, input ready);
  modport sink(input valid, slot_process, finished, finished_process, completion_time,
               turnaround, waiting, all_done, output ready);
endinterface

// ----- hw/rtl/cps_datapath.sv -----
module cps_datapath (
  input  logic clk_i,
  input  logic rst_ni,
  input  cps_pkg::cps_cmd_t cmd_i,
  output cps_pkg::cps_stat_t stat_o,
  input  logic [cps_pkg::TimeBits-1:0] arrival_i,
  input  logic [cps_pkg::BurstBits-1:0] burst_i,
  input  logic [cps_pkg::PrioBits-1:0] prio_i,
  input  logic [cps_pkg::QuantBits-1:0] quantum_i,
  output logic [4:0] slot_o,
  output logic finished_o,
  output logic [4:0] fin_proc_o,
  output logic [cps_pkg::TimeBits-1:0] ct_o,
  output logic [cps_pkg::TimeBits-1:0] tat_o,
  output logic [cps_pkg::TimeBits-1:0] wt_o,
  output logic all_done_o
);
  import cps_pkg::*;

  localparam int MaxProc = MaxProcesses;
  localparam int TBits = TimeBits;
  localparam int IdxBits = $clog2(MaxProc);
  localparam int CntBits = $clog2(MaxProc + 1);
  localparam logic [TBits-1:0] TMax = '1;

  logic [TBits-1:0] arr_q [MaxProc];
  logic [BurstBits-1:0] bst_q [MaxProc];
  logic [BurstBits-1:0] rem_q [MaxProc];
  logic [PrioBits-1:0] pri_q [MaxProc];

  logic [CntBits-1:0] count_q, done_q;
  logic [TBits-1:0] time_q;
  logic [IdxBits-1:0] run_q;
  logic run_valid_q;
  logic [QuantBits-1:0] qused_q;

  // Scan state.
  logic busy_q, found_q, done_flag_q;
  logic [CntBits-1:0] pos_q;
  logic [IdxBits-1:0] best_q;
  logic [BurstBits-1:0] bv_q;
  scan_e kind_q;

  // Set when this tick kept the current runner.
  logic kept_q;

  logic [IdxBits-1:0] pi;
  logic in_range, ready_e, unfin;
  logic [BurstBits-1:0] key;
  logic [CntBits-1:0] start;
  logic [QuantBits-1:0] tq;

  assign pi = pos_q[IdxBits-1:0];
  assign in_range = pos_q < count_q;
  assign unfin = rem_q[pi] != '0;
  assign ready_e = (arr_q[pi] <= time_q) && unfin;
  assign tq = (quantum_i == '0) ? QuantBits'(1) : quantum_i;
  assign start = run_valid_q ? (CntBits'(run_q) + CntBits'(1)) : '0;

  always_comb begin
    case (kind_q)
      ScanBurst: key = bst_q[pi];
      ScanRem:   key = rem_q[pi];
      ScanPrio:  key = BurstBits'(pri_q[pi]);
      default:   key = '0;
    endcase
  end

  assign stat_o.cur_live = run_valid_q && (CntBits'(run_q) < count_q) && (rem_q[run_q] != '0);
  assign stat_o.rr_keep = stat_o.cur_live && (qused_q < tq);
  assign stat_o.start_nonzero = start != '0;
  assign stat_o.scan_done = done_flag_q;
  assign stat_o.sel_found = found_q;

  logic [IdxBits-1:0] s;
  logic [BurstBits-1:0] rem_new;
  logic [TBits-1:0] t_new, tat, wt;
  assign s = best_q;
  assign rem_new = rem_q[s] - BurstBits'(1);
  assign t_new = (time_q < TMax) ? time_q + TBits'(1) : time_q;
  assign tat = (t_new >= arr_q[s]) ? t_new - arr_q[s] : '0;
  assign wt = (tat >= TBits'(bst_q[s])) ? tat - TBits'(bst_q[s]) : '0;

  // Table storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && count_q < CntBits'(MaxProc)) begin
      arr_q[count_q[IdxBits-1:0]] <= arrival_i;
      bst_q[count_q[IdxBits-1:0]] <= (burst_i == '0) ? BurstBits'(1) : burst_i;
      rem_q[count_q[IdxBits-1:0]] <= (burst_i == '0) ? BurstBits'(1) : burst_i;
      pri_q[count_q[IdxBits-1:0]] <= prio_i;
    end else if (cmd_i.commit && found_q) begin
      rem_q[s] <= rem_new;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_o <= found_q ? 5'(s) + 5'd1 : '0;
      finished_o <= found_q && rem_new == '0;
      fin_proc_o <= (found_q && rem_new == '0) ? 5'(s) + 5'd1 : '0;
      ct_o <= (found_q && rem_new == '0) ? t_new : '0;
      tat_o <= (found_q && rem_new == '0) ? tat : '0;
      wt_o <= (found_q && rem_new == '0) ? wt : '0;
      all_done_o <= (done_q + CntBits'(found_q && rem_new == '0)) >= count_q;
    end
  end

  // Scheduler state and serial scan, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; done_q <= '0; time_q <= '0; run_q <= '0;
      run_valid_q <= 1'b0; qused_q <= '0; busy_q <= 1'b0; found_q <= 1'b0;
      done_flag_q <= 1'b0; pos_q <= '0; best_q <= '0;
      bv_q <= '0; kind_q <= ScanFirst;
    end else begin
      done_flag_q <= 1'b0;
      if (cmd_i.clear) begin
        count_q <= '0; done_q <= '0; time_q <= '0; run_q <= '0;
        run_valid_q <= 1'b0; qused_q <= '0;
      end else if (cmd_i.load) begin
        if (count_q < CntBits'(MaxProc)) count_q <= count_q + CntBits'(1);
      end else if (cmd_i.keep_cur) begin
        found_q <= 1'b1; best_q <= run_q; done_flag_q <= 1'b1;
      end else if (cmd_i.scan_start) begin
        busy_q <= 1'b1; kind_q <= cmd_i.kind; found_q <= 1'b0;
        pos_q <= (cmd_i.kind == ScanFrom && !cmd_i.from_zero) ? start : '0;
      end else if (busy_q) begin
        if (!in_range) begin
          busy_q <= 1'b0; done_flag_q <= 1'b1;
        end else begin
          pos_q <= pos_q + CntBits'(1);
          case (kind_q)
            ScanFirst: begin
              if (unfin) begin
                found_q <= ready_e; best_q <= pi; busy_q <= 1'b0; done_flag_q <= 1'b1;
              end
            end
            ScanFrom: begin
              if (ready_e) begin
                found_q <= 1'b1; best_q <= pi; busy_q <= 1'b0; done_flag_q <= 1'b1;
              end
            end
            default: begin
              if (ready_e && (!found_q || key < bv_q)) begin
                found_q <= 1'b1; best_q <= pi; bv_q <= key;
              end
            end
          endcase
        end
      end else if (cmd_i.commit) begin
        time_q <= t_new;
        if (found_q) begin
          if (!kept_q || run_q != s) qused_q <= QuantBits'(1);
          else if (qused_q != '1) qused_q <= qused_q + QuantBits'(1);
          run_q <= s; run_valid_q <= 1'b1;
          if (rem_new == '0) done_q <= done_q + CntBits'(1);
        end else begin
          run_valid_q <= 1'b0; qused_q <= '0;
        end
      end
    end
  end

  // Remember whether this tick kept the current runner.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) kept_q <= 1'b0;
    else if (cmd_i.keep_cur) kept_q <= 1'b1;
    else if (cmd_i.scan_start) kept_q <= 1'b0;
  end

endmodule

// ----- hw/rtl/cps_ctrl.sv -----
module cps_ctrl (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [1:0] func_i,
  input  logic [2:0] policy_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cps_pkg::cps_cmd_t cmd_o,
  input  cps_pkg::cps_stat_t stat_i
);
  import cps_pkg::*;

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StSel    = 5'b00010,
    StRetry  = 5'b00100,
    StWait   = 5'b01000,
    StCommit = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic [2:0] mode;
  logic acc;

  assign mode = (policy_i > PolRr) ? PolFcfs : policy_i;
  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.kind = ScanFirst;
    case (state_q)
      StIdle: begin
        if (acc) begin
          case (func_i)
            FuncLoad:  cmd_o.load = 1'b1;
            FuncClear: cmd_o.clear = 1'b1;
            FuncTick: begin
              state_d = StWait;
              case (mode)
                PolSrtn:  begin cmd_o.scan_start = 1'b1; cmd_o.kind = ScanRem; end
                PolPrioP: begin cmd_o.scan_start = 1'b1; cmd_o.kind = ScanPrio; end
                PolRr: begin
                  if (stat_i.rr_keep) cmd_o.keep_cur = 1'b1;
                  else begin
                    cmd_o.scan_start = 1'b1; cmd_o.kind = ScanFrom; state_d = StSel;
                  end
                end
                default: begin
                  if (stat_i.cur_live) cmd_o.keep_cur = 1'b1;
                  else begin
                    cmd_o.scan_start = 1'b1;
                    cmd_o.kind = (mode == PolSjf) ? ScanBurst :
                                 (mode == PolPrio) ? ScanPrio : ScanFirst;
                  end
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      StSel: begin
        if (stat_i.scan_done) begin
          if (!stat_i.sel_found && stat_i.start_nonzero) begin
            cmd_o.scan_start = 1'b1; cmd_o.kind = ScanFrom; cmd_o.from_zero = 1'b1;
            state_d = StWait;
          end else state_d = StCommit;
        end
      end
      StRetry: state_d = StWait;
      StWait: if (stat_i.scan_done) state_d = StCommit;
      StCommit: begin
        cmd_o.commit = 1'b1; out_valid_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
    end
  end
endmodule

// ----- hw/rtl/cpu_process_scheduler_top.sv -----
// A tick that picks a new runner scans the table serially, one entry per cycle;
// in round robin the scan wraps to entry zero if the first pass finds no one.
// Load and clear items produce no result.
// One item at a time; a new item is taken once the result has been delivered.
// Asynchronous active-low reset empties the table, zeroes time and sets
// policy to FCFS with a quantum of one.
module cpu_process_scheduler_top (
  input  logic clk_i,
  input  logic rst_ni,
  cps_in_if.sink in_if,
  cps_out_if.source out_if,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [cps_pkg::CfgDataBits-1:0] cfg_data_i
);
  import cps_pkg::*;

  logic [2:0] policy_q;
  logic [QuantBits-1:0] quantum_q;
  cps_cmd_t cmd;
  cps_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolFcfs; quantum_q <= QuantBits'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgPolicy) policy_q <= cfg_data_i[2:0];
      else quantum_q <= cfg_data_i[QuantBits-1:0];
    end
  end

  cps_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .func_i(in_if.func),
    .policy_i(policy_q), .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .stat_i(stat)
  );

  cps_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .arrival_i(in_if.arrival_time), .burst_i(in_if.burst_time),
    .prio_i(in_if.priority_level), .quantum_i(quantum_q),
    .slot_o(out_if.slot_process), .finished_o(out_if.finished),
    .fin_proc_o(out_if.finished_process), .ct_o(out_if.completion_time),
    .tat_o(out_if.turnaround), .wt_o(out_if.waiting), .all_done_o(out_if.all_done)
  );
endmodule
